// ----- hdl/pcl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types, constants and helpers for the palette color lookup block.
// ----------------------------------------------------------------------------
package pcl_pkg;

  localparam int unsigned PALETTE_ENTRIES = 32;
  localparam int unsigned ENTRY_AW        = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CHAN_W          = 8;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;

  // Register word index, taken from paddr[2]
  localparam logic REG_PALETTE_SIZE_MODE = 1'b0;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } pcl_cmd_e;

  typedef enum logic {
    MODE_16 = 1'b0,
    MODE_32 = 1'b1
  } pcl_mode_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pcl_rgb_t;

  typedef struct packed {
    logic                en;
    logic [ENTRY_AW-1:0] addr;
    pcl_rgb_t            data;
  } pcl_wr_t;

  typedef struct packed {
    logic                en;
    logic [ENTRY_AW-1:0] addr_a;
    logic [ENTRY_AW-1:0] addr_b;
  } pcl_rd_t;

  // (a * b) >> 8 with b up to 256; product stays below 2^16 for b <= 256
  function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W:0]   b);
    logic [2*CHAN_W:0] prod;
    prod = {{(CHAN_W+1){1'b0}}, a} * {{CHAN_W{1'b0}}, b};
    return prod[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage : pcl_pkg
`default_nettype wire

// ----- hdl/pcl_palette.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcl_palette
// Palette store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pcl_palette
  import pcl_pkg::*;
(
  input  wire logic     clk_i,
  input  wire pcl_wr_t  wr_i,
  input  wire pcl_rd_t  rd_i,
  output pcl_rgb_t      rd_data_a_o,
  output pcl_rgb_t      rd_data_b_o
);

  pcl_rgb_t mem_q [PALETTE_ENTRIES];
  pcl_rgb_t rd_a_q;
  pcl_rgb_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data held while a lookup waits downstream
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_a_q <= mem_q[rd_i.addr_a];
      rd_b_q <= mem_q[rd_i.addr_b];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule : pcl_palette
`default_nettype wire

// ----- hdl/palette_color_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// palette_color_lookup
// RGB palette lookup with linear blend toward the next entry and brightness.
// ----------------------------------------------------------------------------
// One beat per clock in both directions unless stalled. A write beat loads
// one palette entry at its accept edge and yields no result; a lookup beat
// yields one color beat through the palette read, blend and brightness
// stages, each a register with its own valid bit. Ready is combinational, so
// the input keeps taking beats while a result waits as long as a bubble is
// left in the pipe. A lookup may directly follow the write it depends on: the
// entry is written at one edge and read at the next. The palette size mode
// (APB word 0, bit 0: 0 = 16 entries, 1 = 32 entries) may be changed only
// while the block is idle. Reading an entry never written gives an undefined
// color. pready is tied high; reads of word 0 return the mode bit.
// ----------------------------------------------------------------------------
module palette_color_lookup
  import pcl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // APB configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,

  // input beats
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                command_i,
  input  wire logic [ENTRY_AW-1:0] entry_address_i,
  input  wire logic [CHAN_W-1:0]   entry_red_i,
  input  wire logic [CHAN_W-1:0]   entry_green_i,
  input  wire logic [CHAN_W-1:0]   entry_blue_i,
  input  wire logic [CHAN_W-1:0]   lookup_index_i,
  input  wire logic [CHAN_W-1:0]   brightness_i,
  input  wire logic                blend_enable_i,

  // result beats
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [CHAN_W-1:0]   red_o,
  output logic      [CHAN_W-1:0]   green_o,
  output logic      [CHAN_W-1:0]   blue_o
);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  pcl_mode_e mode_q, mode_d;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    mode_d = mode_q;
    if (cfg_wr && paddr[2] == REG_PALETTE_SIZE_MODE) begin
      mode_d = pcl_mode_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_16;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PALETTE_SIZE_MODE) begin
      prdata[0] = mode_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: each stage loads when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic adv1, adv2, adv3;
  logic accept, is_lookup;

  assign adv3       = ~s3_valid_q | out_ready_i;
  assign adv2       = ~s2_valid_q | adv3;
  assign adv1       = ~s1_valid_q | adv2;
  assign in_ready_o = adv1;
  assign accept     = in_valid_i & adv1;
  assign is_lookup  = pcl_cmd_e'(command_i) == CMD_LOOKUP;

  // --------------------------------------------------------------------------
  // Stage 1: address decode and palette read
  // --------------------------------------------------------------------------
  logic [ENTRY_AW-1:0] hi_addr, nxt_addr;
  logic [CHAN_W-1:0]   f2;
  logic                frac_nz;
  pcl_wr_t             wr;
  pcl_rd_t             rd;
  pcl_rgb_t            e1, e2;

  // The next entry wraps to 0 from the last one: plain modulo increment of
  // the 4- or 5-bit entry number.
  always_comb begin
    unique case (mode_q)
      MODE_32: begin
        hi_addr  = lookup_index_i[7:3];
        nxt_addr = lookup_index_i[7:3] + 5'd1;
        f2       = {lookup_index_i[2:0], 5'b0};
        frac_nz  = |lookup_index_i[2:0];
      end
      default: begin
        hi_addr  = {1'b0, lookup_index_i[7:4]};
        nxt_addr = {1'b0, lookup_index_i[7:4] + 4'd1};
        f2       = {lookup_index_i[3:0], 4'b0};
        frac_nz  = |lookup_index_i[3:0];
      end
    endcase
  end

  assign wr.en     = accept & ~is_lookup;
  assign wr.addr   = entry_address_i;
  assign wr.data   = '{red: entry_red_i, green: entry_green_i, blue: entry_blue_i};
  assign rd.en     = accept & is_lookup;
  assign rd.addr_a = hi_addr;
  assign rd.addr_b = nxt_addr;

  pcl_palette u_palette (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_i        (rd),
    .rd_data_a_o (e1),
    .rd_data_b_o (e2)
  );

  logic [CHAN_W-1:0] s1_f2_q, s1_bright_q;
  logic              s1_blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv1) begin
      s1_valid_q <= in_valid_i & is_lookup;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd.en) begin
      s1_f2_q     <= f2;
      s1_bright_q <= brightness_i;
      s1_blend_q  <= frac_nz & blend_enable_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: blend c1*(255-f2) + c2*f2, both scaled by 1/256
  // --------------------------------------------------------------------------
  logic [CHAN_W:0]   f1, f2_ext;
  pcl_rgb_t          blend_c;
  pcl_rgb_t          s2_color_q;
  logic [CHAN_W-1:0] s2_bright_q;

  assign f2_ext = {1'b0, s1_f2_q};
  assign f1     = {1'b0, 8'hFF - s1_f2_q};

  always_comb begin
    blend_c = e1;
    if (s1_blend_q) begin
      // sum never exceeds 254
      blend_c.red   = scale8(e1.red,   f1) + scale8(e2.red,   f2_ext);
      blend_c.green = scale8(e1.green, f1) + scale8(e2.green, f2_ext);
      blend_c.blue  = scale8(e1.blue,  f1) + scale8(e2.blue,  f2_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_valid_q) begin
      s2_color_q  <= blend_c;
      s2_bright_q <= s1_bright_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: brightness. c*(b+1)>>8 already covers the edge cases: b = 255
  // gives c, b = 0 gives 0, and a zero channel stays zero.
  // --------------------------------------------------------------------------
  logic [CHAN_W:0] bright_p1;
  pcl_rgb_t        lit_c;
  pcl_rgb_t        s3_color_q;

  assign bright_p1   = {1'b0, s2_bright_q} + 9'd1;
  assign lit_c.red   = scale8(s2_color_q.red,   bright_p1);
  assign lit_c.green = scale8(s2_color_q.green, bright_p1);
  assign lit_c.blue  = scale8(s2_color_q.blue,  bright_p1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_valid_q) begin
      s3_color_q <= lit_c;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign red_o       = s3_color_q.red;
  assign green_o     = s3_color_q.green;
  assign blue_o      = s3_color_q.blue;

`ifndef SYNTHESIS
  // a write beat never enters the result pipe
  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_lookup |=> !s1_valid_q)
    else $error("write beat produced a pipeline entry");

  // a lookup beat always occupies stage 1 next cycle
  a_lookup_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_lookup |=> s1_valid_q)
    else $error("lookup beat lost at stage 1");

  // a stalled stage 2 entry keeps its color
  a_s2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !adv3 |=> s2_valid_q && $stable(s2_color_q))
    else $error("stage 2 changed during stall");

  // full brightness passes the blended color through unchanged
  a_full_bright : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && adv3 && s2_bright_q == 8'hFF |=> s3_color_q == $past(s2_color_q))
    else $error("brightness 255 altered the color");

  // zero brightness gives black
  a_zero_bright : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && adv3 && s2_bright_q == 8'h00 |=> s3_color_q == '0)
    else $error("brightness 0 did not give black");
`endif

endmodule : palette_color_lookup
`default_nettype wire

// ----- tb/sv/palette_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_tb_pkg
// Beat type and scoreboard for the palette color lookup testbench. The
// scoreboard keeps its own palette copy and queues the expected colors.
// ----------------------------------------------------------------------------
package palette_tb_pkg;

  import pcl_pkg::*;

  localparam logic [ENTRY_AW-1:0] LAST_ENTRY_32 = ENTRY_AW'(PALETTE_ENTRIES - 1);
  localparam logic [ENTRY_AW-1:0] LAST_ENTRY_16 = ENTRY_AW'(PALETTE_ENTRIES / 2 - 1);

  // one input beat, all fields present whatever the command
  typedef struct packed {
    pcl_cmd_e            command;
    logic [ENTRY_AW-1:0] addr;
    pcl_rgb_t            color;
    logic [CHAN_W-1:0]   index;
    logic [CHAN_W-1:0]   bright;
    logic                blend;
  } palette_beat_t;

  class palette_scoreboard;
    pcl_rgb_t    palette[PALETTE_ENTRIES];
    bit          loaded[PALETTE_ENTRIES];
    pcl_mode_e   mode;
    pcl_rgb_t    expected_colors[$];
    int unsigned errors;

    function new();
      mode   = MODE_16;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_colors.size();
    endfunction

    // entry pair and weight of the upper entry for a lookup index
    function void decode_index(input  logic [CHAN_W-1:0]   index,
                               output logic [ENTRY_AW-1:0] base,
                               output logic [ENTRY_AW-1:0] nxt,
                               output int unsigned         w_next);
      logic [ENTRY_AW-1:0] last;
      if (mode == MODE_32) begin
        base   = index[7:3];
        w_next = 32'({index[2:0], 5'b00000});
        last   = LAST_ENTRY_32;
      end else begin
        base   = {1'b0, index[7:4]};
        w_next = 32'({index[3:0], 4'b0000});
        last   = LAST_ENTRY_16;
      end
      nxt = (base == last) ? '0 : base + 1'b1;
    endfunction

    // true when the lookup reads only entries that were loaded
    function bit lookup_is_safe(logic [CHAN_W-1:0] index, logic blend);
      logic [ENTRY_AW-1:0] base, nxt;
      int unsigned         w_next;
      decode_index(index, base, nxt, w_next);
      return loaded[base] && (w_next == 0 || !blend || loaded[nxt]);
    endfunction

    function logic [CHAN_W-1:0] mix_channel(logic [CHAN_W-1:0] a,
                                            logic [CHAN_W-1:0] b,
                                            int unsigned wa, int unsigned wb);
      return CHAN_W'(((32'(a) * wa) >> 8) + ((32'(b) * wb) >> 8));
    endfunction

    function logic [CHAN_W-1:0] dim_channel(logic [CHAN_W-1:0] c,
                                            logic [CHAN_W-1:0] bright);
      int unsigned v;
      v = (32'(c) * (32'(bright) + 32'd1)) >> 8;
      if (bright == '0 || c == '0) return '0;
      return v[CHAN_W-1:0];
    endfunction

    function pcl_rgb_t predict_color(logic [CHAN_W-1:0] index,
                                     logic [CHAN_W-1:0] bright, logic blend);
      logic [ENTRY_AW-1:0] base, nxt;
      int unsigned         w_next, w_base;
      pcl_rgb_t            color, upper;
      decode_index(index, base, nxt, w_next);
      color = palette[base];
      if (w_next != 0 && blend) begin
        upper       = palette[nxt];
        w_base      = 255 - w_next;
        color.red   = mix_channel(color.red,   upper.red,   w_base, w_next);
        color.green = mix_channel(color.green, upper.green, w_base, w_next);
        color.blue  = mix_channel(color.blue,  upper.blue,  w_base, w_next);
      end
      if (bright != 8'hFF) begin
        color.red   = dim_channel(color.red,   bright);
        color.green = dim_channel(color.green, bright);
        color.blue  = dim_channel(color.blue,  bright);
      end
      return color;
    endfunction

    function void note_beat(palette_beat_t b);
      if (b.command == CMD_WRITE) begin
        palette[b.addr] = b.color;
        loaded[b.addr]  = 1'b1;
      end else begin
        expected_colors.push_back(predict_color(b.index, b.bright, b.blend));
      end
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
      errors++;
    endtask

    task check_color(pcl_rgb_t got);
      pcl_rgb_t want;
      if (expected_colors.size() == 0) begin
        report_mismatch("color beat with none expected", 32'(got), 0);
      end else begin
        want = expected_colors.pop_front();
        if (got.red !== want.red)
          report_mismatch("red",   32'(got.red),   32'(want.red));
        if (got.green !== want.green)
          report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
          report_mismatch("blue",  32'(got.blue),  32'(want.blue));
      end
    endtask
  endclass

endpackage : palette_tb_pkg

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Palette color lookup: directed beats in both palette sizes, then random
// write and lookup beats under varying back pressure, checked beat by beat.
// ----------------------------------------------------------------------------
module testbench;

  import pcl_pkg::*;
  import palette_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PHASE_BEATS  = 100;
  localparam int unsigned HOLD_CYCLES  = 120;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 8;    // pipe is three stages deep
  localparam logic [PADDR_W-1:0] MODE_REG_ADDR = {REG_PALETTE_SIZE_MODE, 2'b00};

  // clock, reset, APB
  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [PDATA_W-1:0]  pwdata          = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // input beat channel
  logic                in_valid_i      = 1'b0;
  logic                in_ready_o;
  logic                command_i       = 1'b0;
  logic [ENTRY_AW-1:0] entry_address_i = '0;
  logic [CHAN_W-1:0]   entry_red_i     = '0;
  logic [CHAN_W-1:0]   entry_green_i   = '0;
  logic [CHAN_W-1:0]   entry_blue_i    = '0;
  logic [CHAN_W-1:0]   lookup_index_i  = '0;
  logic [CHAN_W-1:0]   brightness_i    = '0;
  logic                blend_enable_i  = 1'b0;

  // result beat channel
  logic                out_valid_o;
  logic                out_ready_i     = 1'b0;
  logic [CHAN_W-1:0]   red_o;
  logic [CHAN_W-1:0]   green_o;
  logic [CHAN_W-1:0]   blue_o;

  palette_scoreboard sb = new();

  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;   // chance per beat slot that the sender idles
  int unsigned recv_idle_pct = 0;   // chance per cycle that out_ready is low
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;

  palette_color_lookup DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .entry_address_i (entry_address_i),
    .entry_red_i     (entry_red_i),
    .entry_green_i   (entry_green_i),
    .entry_blue_i    (entry_blue_i),
    .lookup_index_i  (lookup_index_i),
    .brightness_i    (brightness_i),
    .blend_enable_i  (blend_enable_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a healthy run finishes far below this count.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. Outputs are sampled right after the edge, so they still hold
  // their pre-edge values; a beat counts when valid and ready were both high.
  // A hold request keeps ready low until its countdown from HOLD_CYCLES ends,
  // so the pipe fills and in_ready drops while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
        sb.check_color({red_o, green_o, blue_o});
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access until pready (tied high in the DUT).
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Set the palette size, read it back, and tell the scoreboard.
  task automatic set_palette_size(input pcl_mode_e mode);
    logic [PDATA_W-1:0] rdata;
    apb_access(1'b1, MODE_REG_ADDR, {{(PDATA_W-1){1'b0}}, mode}, rdata);
    apb_access(1'b0, MODE_REG_ADDR, '0, rdata);
    if (rdata !== {{(PDATA_W-1){1'b0}}, mode})
      sb.report_mismatch("palette size readback", rdata, 32'(mode));
    sb.mode = mode;
  endtask

  // --------------------------------------------------------------------------
  // Sender. Idle slots come before the beat; valid then stays up with the
  // payload fixed until the accept edge. Valid is not lowered after accept,
  // so back-to-back beats never see two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input palette_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= b.command;
    entry_address_i <= b.addr;
    entry_red_i     <= b.color.red;
    entry_green_i   <= b.color.green;
    entry_blue_i    <= b.color.blue;
    lookup_index_i  <= b.index;
    brightness_i    <= b.bright;
    blend_enable_i  <= b.blend;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(b);
  endtask

  // Stop offering, wait out every expected color, then idle for DRAIN_CYCLES.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // bytes lean toward the extremes now and then
  function automatic logic [CHAN_W-1:0] random_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // Unused fields of a beat carry random noise.
  function automatic palette_beat_t write_beat(logic [ENTRY_AW-1:0] addr,
                                               logic [CHAN_W-1:0] r,
                                               logic [CHAN_W-1:0] g,
                                               logic [CHAN_W-1:0] b);
    palette_beat_t beat;
    beat.command = CMD_WRITE;
    beat.addr    = addr;
    beat.color   = {r, g, b};
    beat.index   = CHAN_W'($urandom_range(0, 255));
    beat.bright  = CHAN_W'($urandom_range(0, 255));
    beat.blend   = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  function automatic palette_beat_t lookup_beat(logic [CHAN_W-1:0] index,
                                                logic [CHAN_W-1:0] bright,
                                                logic blend);
    palette_beat_t beat;
    beat.command = CMD_LOOKUP;
    beat.addr    = ENTRY_AW'($urandom_range(0, PALETTE_ENTRIES - 1));
    beat.color   = {random_byte(), random_byte(), random_byte()};
    beat.index   = index;
    beat.bright  = bright;
    beat.blend   = blend;
    return beat;
  endfunction

  // About one beat in three is a write. Lookups only touch loaded entries;
  // entry 0 is loaded first thing, so the fallback is always safe.
  function automatic palette_beat_t random_beat();
    logic [CHAN_W-1:0] index;
    logic              blend;
    bit                found;
    if ($urandom_range(0, 99) < 30)
      return write_beat(ENTRY_AW'($urandom_range(0, PALETTE_ENTRIES - 1)),
                        random_byte(), random_byte(), random_byte());
    found = 1'b0;
    for (int i = 0; i < 20 && !found; i++) begin
      index = CHAN_W'($urandom_range(0, 255));
      blend = 1'($urandom_range(0, 1));
      found = sb.lookup_is_safe(index, blend);
    end
    if (!found) begin
      index = 8'h00;
      blend = 1'b0;
    end
    return lookup_beat(index, random_byte(), blend);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed, 16-entry palette ----
    set_palette_size(MODE_16);
    send_beat(write_beat(5'd0,  8'hFF, 8'hFF, 8'hFF));
    send_beat(write_beat(5'd1,  8'h00, 8'h00, 8'h00));
    send_beat(write_beat(5'd15, 8'h80, 8'h01, 8'hFE));
    send_beat(write_beat(5'd16, 8'h5A, 8'hA5, 8'h3C));  // stored, out of reach here
    send_beat(write_beat(5'd31, 8'h01, 8'hFF, 8'h00));
    send_beat(lookup_beat(8'h00, 8'hFF, 1'b1));  // zero fraction: no blend
    send_beat(lookup_beat(8'h08, 8'hFF, 1'b1));  // halfway white to black
    send_beat(lookup_beat(8'h08, 8'hFF, 1'b0));  // blend off: lower entry
    send_beat(lookup_beat(8'h0F, 8'hFF, 1'b1));  // largest fraction
    send_beat(lookup_beat(8'hF1, 8'hFF, 1'b1));  // last entry wraps to entry 0
    send_beat(lookup_beat(8'hFF, 8'h00, 1'b1));  // brightness 0: black
    send_beat(lookup_beat(8'hF0, 8'h01, 1'b0));  // dimmest nonzero brightness
    send_beat(lookup_beat(8'hF0, 8'hFE, 1'b0));
    send_beat(lookup_beat(8'h10, 8'h80, 1'b0));  // black stays black
    send_beat(lookup_beat(8'h01, 8'h80, 1'b1));
    drain_pipe();

    // ---- directed, 32-entry palette ----
    set_palette_size(MODE_32);
    send_beat(write_beat(5'd17, 8'h00, 8'h80, 8'hFF));
    send_beat(write_beat(5'd30, 8'h7F, 8'h7F, 8'h7F));
    send_beat(lookup_beat(8'h04, 8'hFF, 1'b1));
    send_beat(lookup_beat(8'hFF, 8'hFF, 1'b1));  // entry 31 wraps to entry 0
    send_beat(lookup_beat(8'hF8, 8'h64, 1'b1));  // zero blue channel kept zero
    send_beat(lookup_beat(8'h7F, 8'hFF, 1'b1));  // entry 15 toward 16
    send_beat(lookup_beat(8'h83, 8'hC8, 1'b1));
    send_beat(lookup_beat(8'hF3, 8'hFE, 1'b1));

    // ---- random phases: size alternates, idling profile rotates ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipe();
      set_palette_size((p % 2 == 0) ? MODE_16 : MODE_32);
      case (p % 3)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // long receiver hold-off while the sender streams at full rate
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // sender pause until every expected color is back
        if (p == 5 && n == PHASE_BEATS / 2) drain_pipe();
        send_beat(random_beat());
      end
    end

    drain_pipe();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule : testbench
